// ----- rtl/qnn_pkg.sv -----
// Shared constants and types for the quad Newell normal unit.
package qnn_pkg;

   localparam int VERTEX_COUNT_DEFAULT = 1024;
   localparam int COORD_WIDTH_DEFAULT = 16;
   localparam int INDEX_WIDTH = 10;
   localparam int NORMAL_WIDTH = 16;
   localparam int FRAC_BITS = 14;
   localparam logic [NORMAL_WIDTH-1:0] NORMAL_ONE = 16'd16384;
   localparam int MAG_LIMIT_BIT = 31;
   localparam int RECIP_SHIFT = 20;

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_QUAD = 1'b1;

   typedef struct packed {
      logic valid;
      logic write;
   } store_cmd_type;

endpackage

// ----- rtl/qnn_store.sv -----
// Vertex store: index reduction pipeline and the single-port vertex memory.
module qnn_store #(
   parameter int VERTEX_COUNT = qnn_pkg::VERTEX_COUNT_DEFAULT,
   parameter int COORD_WIDTH = qnn_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  qnn_pkg::store_cmd_type           cmd,
   input  logic [qnn_pkg::INDEX_WIDTH-1:0]  cmd_index,
   input  logic [3*COORD_WIDTH-1:0]         cmd_data,
   output logic                             rd_valid,
   output logic [3*COORD_WIDTH-1:0]         rd_data
);
   import qnn_pkg::*;

   localparam int ADDR_WIDTH = $clog2(VERTEX_COUNT);
   localparam int RECIP = (1 << RECIP_SHIFT) / VERTEX_COUNT;
   localparam int RECIP_WIDTH = $clog2(RECIP + 1);
   localparam int PROD_WIDTH = INDEX_WIDTH + RECIP_WIDTH;
   localparam int CNT_WIDTH = $clog2(VERTEX_COUNT + 1);
   localparam int QV_WIDTH = INDEX_WIDTH + CNT_WIDTH;
   localparam int SLOT_WIDTH = (ADDR_WIDTH > INDEX_WIDTH ? ADDR_WIDTH : INDEX_WIDTH) + 1;

   logic [3*COORD_WIDTH-1:0] mem [VERTEX_COUNT];

   store_cmd_type            cmd1_ff;
   logic [INDEX_WIDTH-1:0]   index1_ff;
   logic [PROD_WIDTH-1:0]    prod_ff;
   logic [3*COORD_WIDTH-1:0] data1_ff;
   store_cmd_type            cmd2_ff;
   logic [ADDR_WIDTH-1:0]    addr_ff;
   logic [3*COORD_WIDTH-1:0] data2_ff;
   logic                     rd_valid_ff;
   logic [3*COORD_WIDTH-1:0] rd_data_ff;

   logic [INDEX_WIDTH-1:0]   quot;
   logic [QV_WIDTH-1:0]      quot_times;
   logic [SLOT_WIDTH-1:0]    rem_raw;
   logic [SLOT_WIDTH-1:0]    rem_fixed;
   logic [ADDR_WIDTH-1:0]    addr_in;

   // The reciprocal estimate is never above the true quotient and at most one below it.
   assign quot = INDEX_WIDTH'(prod_ff >> RECIP_SHIFT);
   assign quot_times = QV_WIDTH'(quot) * QV_WIDTH'(VERTEX_COUNT);
   assign rem_raw = SLOT_WIDTH'(index1_ff) - SLOT_WIDTH'(quot_times[INDEX_WIDTH-1:0]);
   assign rem_fixed = (rem_raw >= SLOT_WIDTH'(VERTEX_COUNT)) ?
                      rem_raw - SLOT_WIDTH'(VERTEX_COUNT) : rem_raw;
   assign addr_in = ADDR_WIDTH'(rem_fixed);

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd1_ff <= '0;
         cmd2_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         cmd1_ff <= cmd;
         cmd2_ff <= cmd1_ff;
         rd_valid_ff <= cmd2_ff.valid && !cmd2_ff.write;
      end
      index1_ff <= cmd_index;
      prod_ff <= PROD_WIDTH'(cmd_index) * PROD_WIDTH'(RECIP);
      data1_ff <= cmd_data;
      addr_ff <= addr_in;
      data2_ff <= data1_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd2_ff.valid && cmd2_ff.write) begin
         mem[addr_ff] <= data2_ff;
      end
      rd_data_ff <= mem[addr_ff];
   end

   assign rd_valid = rd_valid_ff;
   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/qnn_newell.sv -----
// Newell sum engine: four-corner ring and one shared multiply-accumulate.
module qnn_newell #(
   parameter int COORD_WIDTH = qnn_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load_valid,
   input  logic [3*COORD_WIDTH-1:0]          load_data,
   output logic                              done,
   output logic signed [2*COORD_WIDTH+3:0]   sum_x,
   output logic signed [2*COORD_WIDTH+3:0]   sum_y,
   output logic signed [2*COORD_WIDTH+3:0]   sum_z
);
   import qnn_pkg::*;

   localparam int SUM_WIDTH = 2 * COORD_WIDTH + 4;
   localparam int PROD_WIDTH = 2 * COORD_WIDTH + 2;
   localparam logic [1:0] COMP_X = 2'd0;
   localparam logic [1:0] COMP_Y = 2'd1;
   localparam logic [1:0] COMP_Z = 2'd2;

   typedef enum logic [1:0] {ST_LOAD, ST_RUN, ST_FLUSH} state_type;

   state_type                      state_ff;
   logic [3*COORD_WIDTH-1:0]       ring_ff [4];
   logic [1:0]                     load_cnt_ff;
   logic [1:0]                     edge_cnt_ff;
   logic [1:0]                     comp_ff;
   logic signed [PROD_WIDTH-1:0]   prod_ff;
   logic                           prod_valid_ff;
   logic [1:0]                     prod_comp_ff;
   logic signed [SUM_WIDTH-1:0]    acc_x_ff;
   logic signed [SUM_WIDTH-1:0]    acc_y_ff;
   logic signed [SUM_WIDTH-1:0]    acc_z_ff;
   logic                           done_ff;

   logic signed [COORD_WIDTH-1:0]  ax, ay, az, bx, by, bz;
   logic signed [COORD_WIDTH:0]    ap, bp, aq, bq, diff, total;
   logic signed [PROD_WIDTH-1:0]   prod_in;

   assign ax = ring_ff[0][COORD_WIDTH-1:0];
   assign ay = ring_ff[0][2*COORD_WIDTH-1:COORD_WIDTH];
   assign az = ring_ff[0][3*COORD_WIDTH-1:2*COORD_WIDTH];
   assign bx = ring_ff[1][COORD_WIDTH-1:0];
   assign by = ring_ff[1][2*COORD_WIDTH-1:COORD_WIDTH];
   assign bz = ring_ff[1][3*COORD_WIDTH-1:2*COORD_WIDTH];

   always_comb begin
      case (comp_ff)
         COMP_X: begin
            ap = (COORD_WIDTH+1)'(ay);
            bp = (COORD_WIDTH+1)'(by);
            aq = (COORD_WIDTH+1)'(az);
            bq = (COORD_WIDTH+1)'(bz);
         end
         COMP_Y: begin
            ap = (COORD_WIDTH+1)'(az);
            bp = (COORD_WIDTH+1)'(bz);
            aq = (COORD_WIDTH+1)'(ax);
            bq = (COORD_WIDTH+1)'(bx);
         end
         default: begin
            ap = (COORD_WIDTH+1)'(ax);
            bp = (COORD_WIDTH+1)'(bx);
            aq = (COORD_WIDTH+1)'(ay);
            bq = (COORD_WIDTH+1)'(by);
         end
      endcase
      diff = ap - bp;
      total = aq + bq;
      prod_in = PROD_WIDTH'(diff) * PROD_WIDTH'(total);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         load_cnt_ff <= '0;
         edge_cnt_ff <= '0;
         comp_ff <= COMP_X;
         prod_valid_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         prod_valid_ff <= (state_ff == ST_RUN);
         case (state_ff)
            ST_LOAD: begin
               if (load_valid) begin
                  load_cnt_ff <= load_cnt_ff + 2'd1;
                  if (load_cnt_ff == 2'd3) begin
                     state_ff <= ST_RUN;
                     edge_cnt_ff <= '0;
                     comp_ff <= COMP_X;
                  end
               end
            end
            ST_RUN: begin
               if (comp_ff == COMP_Z) begin
                  comp_ff <= COMP_X;
                  edge_cnt_ff <= edge_cnt_ff + 2'd1;
                  if (edge_cnt_ff == 2'd3) begin
                     state_ff <= ST_FLUSH;
                  end
               end else begin
                  comp_ff <= comp_ff + 2'd1;
               end
            end
            ST_FLUSH: begin
               done_ff <= 1'b1;
               state_ff <= ST_LOAD;
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end

      if (state_ff == ST_LOAD && load_valid) begin
         ring_ff[3] <= load_data;
         for (int i = 0; i < 3; i++) begin
            ring_ff[i] <= ring_ff[i+1];
         end
      end else if (state_ff == ST_RUN && comp_ff == COMP_Z) begin
         ring_ff[3] <= ring_ff[0];
         for (int i = 0; i < 3; i++) begin
            ring_ff[i] <= ring_ff[i+1];
         end
      end

      prod_ff <= prod_in;
      prod_comp_ff <= comp_ff;

      if (state_ff == ST_LOAD && load_valid && load_cnt_ff == 2'd3) begin
         acc_x_ff <= '0;
         acc_y_ff <= '0;
         acc_z_ff <= '0;
      end else if (prod_valid_ff) begin
         case (prod_comp_ff)
            COMP_X:  acc_x_ff <= acc_x_ff + SUM_WIDTH'(prod_ff);
            COMP_Y:  acc_y_ff <= acc_y_ff + SUM_WIDTH'(prod_ff);
            default: acc_z_ff <= acc_z_ff + SUM_WIDTH'(prod_ff);
         endcase
      end
   end

   assign done = done_ff;
   assign sum_x = acc_x_ff;
   assign sum_y = acc_y_ff;
   assign sum_z = acc_z_ff;

endmodule

// ----- rtl/qnn_norm.sv -----
// Normalizer: range shift, sum of squares, bit-serial square root and three dividers.
module qnn_norm #(
   parameter int COORD_WIDTH = qnn_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [2*COORD_WIDTH+3:0]       sum_x,
   input  logic signed [2*COORD_WIDTH+3:0]       sum_y,
   input  logic signed [2*COORD_WIDTH+3:0]       sum_z,
   output logic                                  done,
   output logic [qnn_pkg::NORMAL_WIDTH-1:0]      normal_x,
   output logic [qnn_pkg::NORMAL_WIDTH-1:0]      normal_y,
   output logic [qnn_pkg::NORMAL_WIDTH-1:0]      normal_z,
   output logic                                  degenerate
);
   import qnn_pkg::*;

   localparam int SUM_WIDTH = 2 * COORD_WIDTH + 4;
   localparam int MAG_WIDTH = (SUM_WIDTH > MAG_LIMIT_BIT + 1) ? SUM_WIDTH : MAG_LIMIT_BIT + 1;
   localparam int SQ_WIDTH = 2 * MAG_LIMIT_BIT;
   localparam int ROOT_WIDTH = 64;
   localparam int LEN_WIDTH = 32;
   localparam int NUM_WIDTH = MAG_LIMIT_BIT + FRAC_BITS + 1;
   localparam int ROOT_STEPS = ROOT_WIDTH / 2;
   localparam int ROOT_CNT_WIDTH = $clog2(ROOT_STEPS);
   localparam int DIV_CNT_WIDTH = $clog2(NORMAL_WIDTH);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SHIFT, ST_SQUARE, ST_ROOT, ST_SETUP, ST_DIVIDE, ST_FINISH
   } state_type;

   state_type                    state_ff;
   logic [MAG_WIDTH-1:0]         mag_ff [3];
   logic                         neg_ff [3];
   logic [1:0]                   sq_cnt_ff;
   logic [SQ_WIDTH-1:0]          sqp_ff;
   logic                         sqp_valid_ff;
   logic [ROOT_WIDTH-1:0]        sq_acc_ff;
   logic [ROOT_WIDTH-1:0]        root_x_ff;
   logic [ROOT_WIDTH-1:0]        root_res_ff;
   logic [ROOT_WIDTH-1:0]        root_bit_ff;
   logic [ROOT_CNT_WIDTH-1:0]    root_cnt_ff;
   logic [LEN_WIDTH-1:0]         len_ff;
   logic [LEN_WIDTH-1:0]         rem_ff [3];
   logic [NORMAL_WIDTH-1:0]      quo_ff [3];
   logic [DIV_CNT_WIDTH-1:0]     div_cnt_ff;
   logic [NORMAL_WIDTH-1:0]      normal_ff [3];
   logic                         degenerate_ff;
   logic                         done_ff;

   logic signed [SUM_WIDTH-1:0]  sum_in [3];
   logic [MAG_WIDTH-1:0]         abs_in [3];
   logic                         all_zero;
   logic                         too_wide;
   logic [MAG_LIMIT_BIT-1:0]     sq_operand;
   logic [ROOT_WIDTH-1:0]        sq_sum;
   logic [ROOT_WIDTH-1:0]        root_trial;
   logic                         root_ge;
   logic [ROOT_WIDTH-1:0]        root_x_in;
   logic [ROOT_WIDTH-1:0]        root_res_in;
   logic [LEN_WIDTH-1:0]         len_in;
   logic [NUM_WIDTH-1:0]         num_in [3];
   logic [LEN_WIDTH:0]           div_trial [3];
   logic                         div_ge [3];
   logic [LEN_WIDTH:0]           div_diff [3];
   logic [NORMAL_WIDTH-1:0]      clamp_in [3];

   assign sum_in[0] = sum_x;
   assign sum_in[1] = sum_y;
   assign sum_in[2] = sum_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         abs_in[i] = MAG_WIDTH'(sum_in[i][SUM_WIDTH-1] ?
                                SUM_WIDTH'(-sum_in[i]) : SUM_WIDTH'(sum_in[i]));
      end
      all_zero = (sum_x == '0) && (sum_y == '0) && (sum_z == '0);
      too_wide = (mag_ff[0][MAG_WIDTH-1:MAG_LIMIT_BIT] != '0) ||
                 (mag_ff[1][MAG_WIDTH-1:MAG_LIMIT_BIT] != '0) ||
                 (mag_ff[2][MAG_WIDTH-1:MAG_LIMIT_BIT] != '0);
      sq_operand = mag_ff[sq_cnt_ff][MAG_LIMIT_BIT-1:0];
      sq_sum = sq_acc_ff + ROOT_WIDTH'(sqp_ff);

      root_trial = root_res_ff + root_bit_ff;
      root_ge = (root_x_ff >= root_trial);
      root_x_in = root_ge ? root_x_ff - root_trial : root_x_ff;
      root_res_in = root_ge ? (root_res_ff >> 1) + root_bit_ff : (root_res_ff >> 1);
      len_in = (root_res_in[LEN_WIDTH-1:0] == '0) ? LEN_WIDTH'(1) : root_res_in[LEN_WIDTH-1:0];

      for (int i = 0; i < 3; i++) begin
         num_in[i] = NUM_WIDTH'({mag_ff[i][MAG_LIMIT_BIT-1:0], {FRAC_BITS{1'b0}}}) +
                     NUM_WIDTH'(len_ff >> 1);
         div_trial[i] = {rem_ff[i], quo_ff[i][NORMAL_WIDTH-1]};
         div_ge[i] = (div_trial[i] >= {1'b0, len_ff});
         div_diff[i] = div_trial[i] - {1'b0, len_ff};
         clamp_in[i] = (quo_ff[i] > NORMAL_ONE) ? NORMAL_ONE : quo_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff <= 1'b0;
         sqp_valid_ff <= 1'b0;
         sq_cnt_ff <= '0;
         root_cnt_ff <= '0;
         div_cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         sqp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  if (all_zero) begin
                     done_ff <= 1'b1;
                  end else begin
                     state_ff <= ST_SHIFT;
                  end
               end
            end
            ST_SHIFT: begin
               if (!too_wide) begin
                  state_ff <= ST_SQUARE;
                  sq_cnt_ff <= '0;
               end
            end
            ST_SQUARE: begin
               if (sq_cnt_ff == 2'd3) begin
                  state_ff <= ST_ROOT;
                  root_cnt_ff <= '0;
               end else begin
                  sqp_valid_ff <= 1'b1;
                  sq_cnt_ff <= sq_cnt_ff + 2'd1;
               end
            end
            ST_ROOT: begin
               root_cnt_ff <= root_cnt_ff + 1'b1;
               if (root_cnt_ff == ROOT_CNT_WIDTH'(ROOT_STEPS - 1)) begin
                  state_ff <= ST_SETUP;
               end
            end
            ST_SETUP: begin
               state_ff <= ST_DIVIDE;
               div_cnt_ff <= '0;
            end
            ST_DIVIDE: begin
               div_cnt_ff <= div_cnt_ff + 1'b1;
               if (div_cnt_ff == DIV_CNT_WIDTH'(NORMAL_WIDTH - 1)) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               done_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               degenerate_ff <= all_zero;
               for (int i = 0; i < 3; i++) begin
                  mag_ff[i] <= abs_in[i];
                  neg_ff[i] <= sum_in[i][SUM_WIDTH-1];
                  normal_ff[i] <= '0;
               end
            end
         end
         ST_SHIFT: begin
            sq_acc_ff <= '0;
            if (too_wide) begin
               for (int i = 0; i < 3; i++) begin
                  mag_ff[i] <= mag_ff[i] >> 1;
               end
            end
         end
         ST_SQUARE: begin
            sqp_ff <= SQ_WIDTH'(sq_operand) * SQ_WIDTH'(sq_operand);
            if (sqp_valid_ff) begin
               sq_acc_ff <= sq_sum;
            end
            root_x_ff <= sq_sum;
            root_res_ff <= '0;
            root_bit_ff <= ROOT_WIDTH'(1) << (ROOT_WIDTH - 2);
         end
         ST_ROOT: begin
            root_x_ff <= root_x_in;
            root_res_ff <= root_res_in;
            root_bit_ff <= root_bit_ff >> 2;
            len_ff <= len_in;
         end
         ST_SETUP: begin
            for (int i = 0; i < 3; i++) begin
               rem_ff[i] <= LEN_WIDTH'(num_in[i] >> NORMAL_WIDTH);
               quo_ff[i] <= num_in[i][NORMAL_WIDTH-1:0];
            end
         end
         ST_DIVIDE: begin
            for (int i = 0; i < 3; i++) begin
               rem_ff[i] <= div_ge[i] ? div_diff[i][LEN_WIDTH-1:0] : div_trial[i][LEN_WIDTH-1:0];
               quo_ff[i] <= {quo_ff[i][NORMAL_WIDTH-2:0], div_ge[i]};
            end
         end
         ST_FINISH: begin
            for (int i = 0; i < 3; i++) begin
               normal_ff[i] <= neg_ff[i] ? NORMAL_WIDTH'(-clamp_in[i]) : clamp_in[i];
            end
         end
         default: begin
         end
      endcase
   end

   assign done = done_ff;
   assign normal_x = normal_ff[0];
   assign normal_y = normal_ff[1];
   assign normal_z = normal_ff[2];
   assign degenerate = degenerate_ff;

endmodule

// ----- rtl/quad_newell_normal_unit.sv -----
// Top level of the quad Newell normal unit: stream handshakes and transaction sequencing.
//
// A vertex write transaction is accepted and gives no response; while no quad is being
// worked on, writes can follow each other on every cycle. A quad transaction reads its
// four corners from the vertex memory one per cycle, forms the Newell sums with one
// shared multiplier, scales the vector with a one-bit-per-cycle square root and three
// restoring dividers running side by side. The response is offered once the dividers
// finish, after any range-shift steps, and the next transaction can be taken in the
// same cycle as the response is offered. A degenerate quad skips the scaling. One
// quad is worked on at a time, and a finished response waits in the output register
// while the next transaction is taken. The vertex memory is not cleared: reading an
// entry that was never written returns an arbitrary normal. Indices are reduced
// modulo VERTEX_COUNT.
module quad_newell_normal_unit #(
   parameter int VERTEX_COUNT = qnn_pkg::VERTEX_COUNT_DEFAULT,
   parameter int COORD_WIDTH = qnn_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // vertex_index, coord_x, coord_y, coord_z, corner0_index .. corner3_index, zero pad
   input  logic [((3*COORD_WIDTH+5*qnn_pkg::INDEX_WIDTH+7)/8)*8-1:0] req_tdata,
   // action
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // normal_x, normal_y, normal_z
   output logic [3*qnn_pkg::NORMAL_WIDTH-1:0] rsp_tdata,
   // degenerate
   output logic rsp_tuser
);
   import qnn_pkg::*;

   localparam int SUM_WIDTH = 2 * COORD_WIDTH + 4;
   localparam int CORNER_BASE = INDEX_WIDTH + 3 * COORD_WIDTH;

   typedef enum logic [1:0] {ST_IDLE, ST_FEED, ST_CALC, ST_EMIT} state_type;

   state_type                    state_ff;
   logic [INDEX_WIDTH-1:0]       corner_ff [4];
   logic [1:0]                   feed_cnt_ff;
   logic                         rsp_valid_ff;
   logic [3*NORMAL_WIDTH-1:0]    rsp_data_ff;
   logic                         rsp_user_ff;

   logic                         req_accept;
   logic                         emit_fire;
   store_cmd_type                store_cmd;
   logic [INDEX_WIDTH-1:0]       store_index;
   logic [3*COORD_WIDTH-1:0]     store_data;
   logic                         rd_valid;
   logic [3*COORD_WIDTH-1:0]     rd_data;
   logic                         newell_done;
   logic signed [SUM_WIDTH-1:0]  sum_x, sum_y, sum_z;
   logic                         norm_done;
   logic [NORMAL_WIDTH-1:0]      normal_x, normal_y, normal_z;
   logic                         degenerate;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign store_data = req_tdata[INDEX_WIDTH +: 3*COORD_WIDTH];
   assign emit_fire = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      store_cmd = '0;
      store_index = corner_ff[0];
      if (state_ff == ST_IDLE && req_accept && req_tuser == ACTION_WRITE) begin
         store_cmd.valid = 1'b1;
         store_cmd.write = 1'b1;
         store_index = req_tdata[INDEX_WIDTH-1:0];
      end else if (state_ff == ST_FEED) begin
         store_cmd.valid = 1'b1;
      end
   end

   qnn_store #(
      .VERTEX_COUNT(VERTEX_COUNT),
      .COORD_WIDTH(COORD_WIDTH)
   ) u_store (
      .clock(clock),
      .reset(reset),
      .cmd(store_cmd),
      .cmd_index(store_index),
      .cmd_data(store_data),
      .rd_valid(rd_valid),
      .rd_data(rd_data)
   );

   qnn_newell #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_newell (
      .clock(clock),
      .reset(reset),
      .load_valid(rd_valid),
      .load_data(rd_data),
      .done(newell_done),
      .sum_x(sum_x),
      .sum_y(sum_y),
      .sum_z(sum_z)
   );

   qnn_norm #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_norm (
      .clock(clock),
      .reset(reset),
      .start(newell_done),
      .sum_x(sum_x),
      .sum_y(sum_y),
      .sum_z(sum_z),
      .done(norm_done),
      .normal_x(normal_x),
      .normal_y(normal_y),
      .normal_z(normal_z),
      .degenerate(degenerate)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         feed_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept && req_tuser == ACTION_QUAD) begin
                  state_ff <= ST_FEED;
                  feed_cnt_ff <= '0;
               end
            end
            ST_FEED: begin
               feed_cnt_ff <= feed_cnt_ff + 2'd1;
               if (feed_cnt_ff == 2'd3) begin
                  state_ff <= ST_CALC;
               end
            end
            ST_CALC: begin
               if (norm_done) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (emit_fire) begin
                  rsp_data_ff <= {normal_z, normal_y, normal_x};
                  rsp_user_ff <= degenerate;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end

      if (state_ff == ST_IDLE && req_accept) begin
         for (int i = 0; i < 4; i++) begin
            corner_ff[i] <= req_tdata[CORNER_BASE + i*INDEX_WIDTH +: INDEX_WIDTH];
         end
      end else if (state_ff == ST_FEED) begin
         for (int i = 0; i < 3; i++) begin
            corner_ff[i] <= corner_ff[i+1];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

endmodule
